/* rtl/core/pdc_pkg.sv */
// Shared types, letter constants and square geometry helpers for the Playfair cipher.
// No dependencies; imported by pdc_front, pdc_back and the top level (not by pdc_ram).
package pdc_pkg;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned Alphabet = 26;
  localparam int unsigned Side     = 5;
  localparam int unsigned Cells    = 25;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [2:0]         coord_t;

  localparam letter_t LetterI = letter_t'(8);
  localparam letter_t LetterJ = letter_t'(9);
  localparam letter_t LetterZ = letter_t'(25);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_FIN = 2'd1,
    OP_ENC = 2'd2
  } op_e;

  typedef struct packed {
    op_e     op;
    letter_t first;
    letter_t second;
  } cmd_t;

  function automatic letter_t clamp_letter(letter_t x);
    return (x > LetterZ) ? LetterZ : x;
  endfunction

  function automatic letter_t cell_index(coord_t r, coord_t c);
    return letter_t'({r, 2'b00}) + letter_t'(r) + letter_t'(c);
  endfunction

  // cell / Side by compare chain
  function automatic coord_t pos_row(letter_t p);
    coord_t r;
    if (p >= letter_t'(4 * Side))      r = coord_t'(4);
    else if (p >= letter_t'(3 * Side)) r = coord_t'(3);
    else if (p >= letter_t'(2 * Side)) r = coord_t'(2);
    else if (p >= letter_t'(Side))     r = coord_t'(1);
    else                               r = coord_t'(0);
    return r;
  endfunction

  function automatic coord_t pos_col(letter_t p);
    letter_t t;
    t = p - cell_index(pos_row(p), coord_t'(0));
    return coord_t'(t);
  endfunction

  function automatic coord_t wrap_inc(coord_t v);
    return (v == coord_t'(Side - 1)) ? coord_t'(0) : v + coord_t'(1);
  endfunction

endpackage

/* rtl/core/pdc_ram.sv */
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module pdc_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/core/pdc_front.sv */
// Front end: accepts input transactions, normalizes letters, drops unused opcodes
// and queues commands for the back end. Depends on pdc_pkg.
module pdc_front #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  input  pdc_pkg::letter_t first_letter_i,
  input  pdc_pkg::letter_t second_letter_i,
  input  logic             pad_second_i,
  output logic             q_valid_o,
  output pdc_pkg::cmd_t    q_cmd_o,
  input  logic             q_pop_i
);
  import pdc_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full;
  logic            keep;
  logic            push;
  cmd_t            cmd_d;
  letter_t         a_n;
  letter_t         b_n;

  assign full       = (count_q == CntW'(Depth));
  assign in_stall_o = full;

  always_comb begin
    a_n          = clamp_letter(first_letter_i);
    b_n          = pad_second_i ? LetterZ : clamp_letter(second_letter_i);
    keep         = 1'b0;
    cmd_d.op     = op_e'(opcode_i);
    cmd_d.first  = a_n;
    cmd_d.second = b_n;
    case (op_e'(opcode_i))
      OP_ADD: keep = 1'b1;
      OP_FIN: keep = 1'b1;
      OP_ENC: begin
        keep = 1'b1;
        // j and i share a cell
        if (a_n == LetterJ) cmd_d.first = LetterI;
        if (b_n == LetterJ) cmd_d.second = LetterI;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = in_valid_i && !full && keep;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !q_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && q_pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_d;
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_cmd_o   = mem_q[rd_ptr_q];

endmodule

/* rtl/core/pdc_back.sv */
// Back end: key square build, completion sweep and pair encryption, plus the output register.
// Depends on pdc_pkg and pdc_ram.
module pdc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  pdc_pkg::cmd_t    q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pdc_pkg::letter_t cipher_first_o,
  output pdc_pkg::letter_t cipher_second_o,
  output logic             status_o
);
  import pdc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;
  localparam logic [1:0] ST_CELL = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [Alphabet-1:0] used_q, used_d;
  letter_t             fill_q, fill_d;
  letter_t             k_q, k_d;
  logic                ready_q, ready_d;

  logic    out_valid_q, out_valid_d;
  letter_t cf_q, cs_q, cf_d, cs_d;
  logic    status_q, status_d;

  logic    out_free;
  logic    place_en;
  logic    place_ok;
  letter_t place_letter;
  logic    load_nr;
  logic    load_enc;

  letter_t pos_a, pos_b;
  letter_t sq_a, sq_b;
  coord_t  ra, ca, rb, cb;
  letter_t idx_a, idx_b;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    ready_d  = ready_q;
    q_pop_o  = 1'b0;
    place_en = 1'b0;
    load_nr  = 1'b0;
    load_enc = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            OP_ADD: begin
              q_pop_o  = 1'b1;
              place_en = !ready_q;
            end
            OP_FIN: begin
              q_pop_o = 1'b1;
              if (!ready_q) begin
                state_d = ST_FILL;
                k_d     = '0;
              end
            end
            OP_ENC: begin
              // output slot is free by the time the result lands
              if (out_free) begin
                q_pop_o = 1'b1;
                if (ready_q) state_d = ST_POS;
                else load_nr = 1'b1;
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      ST_FILL: begin
        place_en = 1'b1;
        k_d      = k_q + letter_t'(1);
        if (k_q == LetterZ) begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_POS:  state_d = ST_CELL;
      ST_CELL: begin
        load_enc = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign place_letter = (state_q == ST_FILL) ? k_q : q_cmd_i.first;
  assign place_ok = place_en && (place_letter != LetterJ) && !used_q[place_letter]
                    && (fill_q < LetterW'(Cells));

  always_comb begin
    used_d = used_q;
    fill_d = fill_q;
    if (place_ok) begin
      used_d[place_letter] = 1'b1;
      fill_d               = fill_q + letter_t'(1);
    end
  end

  pdc_ram #(.Width(LetterW), .Depth(Alphabet)) u_pos_ram (
    .clk_i     (clk_i),
    .we_i      (place_ok),
    .waddr_i   (place_letter),
    .wdata_i   (fill_q),
    .raddr_a_i (q_cmd_i.first),
    .rdata_a_o (pos_a),
    .raddr_b_i (q_cmd_i.second),
    .rdata_b_o (pos_b)
  );

  always_comb begin
    ra = pos_row(pos_a);
    ca = pos_col(pos_a);
    rb = pos_row(pos_b);
    cb = pos_col(pos_b);
    if (ra == rb) begin
      idx_a = cell_index(ra, wrap_inc(ca));
      idx_b = cell_index(rb, wrap_inc(cb));
    end else if (ca == cb) begin
      idx_a = cell_index(wrap_inc(ra), ca);
      idx_b = cell_index(wrap_inc(rb), cb);
    end else begin
      idx_a = cell_index(ra, cb);
      idx_b = cell_index(rb, ca);
    end
  end

  pdc_ram #(.Width(LetterW), .Depth(Cells)) u_sq_ram (
    .clk_i     (clk_i),
    .we_i      (place_ok),
    .waddr_i   (fill_q),
    .wdata_i   (place_letter),
    .raddr_a_i (idx_a),
    .rdata_a_o (sq_a),
    .raddr_b_i (idx_b),
    .rdata_b_o (sq_b)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    cf_d        = cf_q;
    cs_d        = cs_q;
    status_d    = status_q;
    if (load_nr) begin
      out_valid_d = 1'b1;
      cf_d        = '0;
      cs_d        = '0;
      status_d    = 1'b1;
    end else if (load_enc) begin
      out_valid_d = 1'b1;
      cf_d        = sq_a;
      cs_d        = sq_b;
      status_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      k_q         <= k_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cf_q     <= cf_d;
    cs_q     <= cs_d;
    status_q <= status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_first_o  = cf_q;
  assign cipher_second_o = cs_q;
  assign status_o        = status_q;

endmodule

/* rtl/core/playfair_digraph_cipher.sv */
// Playfair 5x5 digraph cipher top level: front-end queue feeding the key/encrypt back end.
// Depends on pdc_pkg, pdc_front, pdc_back (and pdc_ram through pdc_back).
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------------
//  in      | in_valid_i / in_stall_o | opcode_i, first_letter_i, second_letter_i, pad_second_i
//  out     | out_valid_o / out_stall_i | cipher_first_o, cipher_second_o, status_o
//
// Key letter: written to both RAMs as its ADD command is popped. Complete: one letter of the
// alphabet per cycle through the single write port of each RAM, then back to idle. Encrypt:
// two registered RAM reads (position map, then square) ahead of the output register.
// Reset clears control state only; the RAMs need no clearing pass.
// The front queue keeps taking transactions while the back end is busy or the output stalls,
// until QueueDepth commands wait; then in_stall_o stays high until the back end pops one.
module playfair_digraph_cipher #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  input  pdc_pkg::letter_t first_letter_i,
  input  pdc_pkg::letter_t second_letter_i,
  input  logic             pad_second_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pdc_pkg::letter_t cipher_first_o,
  output pdc_pkg::letter_t cipher_second_o,
  output logic             status_o
);
  import pdc_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  pdc_front #(.Depth(QueueDepth)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .first_letter_i  (first_letter_i),
    .second_letter_i (second_letter_i),
    .pad_second_i    (pad_second_i),
    .q_valid_o       (q_valid),
    .q_cmd_o         (q_cmd),
    .q_pop_i         (q_pop)
  );

  pdc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_first_o  (cipher_first_o),
    .cipher_second_o (cipher_second_o),
    .status_o        (status_o)
  );

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (cipher_first_o == '0 && cipher_second_o == '0))
    else $error("not-ready result carries letters");

  a_cipher_letters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |->
      (cipher_first_o != LetterJ && cipher_second_o != LetterJ &&
       cipher_first_o <= LetterZ && cipher_second_o <= LetterZ))
    else $error("cipher letter outside the square");

  a_result_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !q_pop) |=> !out_valid_o || $past(q_valid) || $past(q_valid, 2)
                                 || $past(q_valid, 3))
    else $error("result appeared without a queued command");
`endif

endmodule
